[hw/rtl/bezier_curve_evaluator_assert.svh]
// ----------------------------------------------------------------------------
// Bezier curve evaluator assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_EVALUATOR_ASSERT_SVH
`define BEZIER_CURVE_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BCE_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("bce: assertion failed");
// Next-cycle implication.
`define BCE_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("bce: assertion failed");
`else
`define BCE_ASSERT_IMP(label, clk, dis, ante, cons)
`define BCE_ASSERT_NXT(label, clk, dis, ante, cons)
`endif
`endif

[hw/rtl/bce_pkg.sv]
// ----------------------------------------------------------------------------
// Bezier curve evaluator package
// Widths, constants and the item types that travel down the pipeline.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int COORD_BITS      = 32;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_BITS      = PHASE_FRAC_BITS + 1;
    localparam int OUT_BITS        = 48;
    localparam int CNT_BITS        = 3;
    localparam int LVL_BITS        = 3;
    // Second differences need two bits above the coordinate width.
    localparam int WORK_BITS       = COORD_BITS + 2;
    localparam int DIFF_BITS       = WORK_BITS + 1;
    localparam int PROD_BITS       = DIFF_BITS + PHASE_BITS + 1;
    localparam int LANES           = 6;
    localparam int LEVELS          = LANES - 1;
    localparam int FACT_BITS       = 6;

    localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC_BITS;
    localparam logic [CNT_BITS-1:0]   MIN_COUNT = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0]   MAX_COUNT = CNT_BITS'(4);

    typedef logic signed [WORK_BITS-1:0] t_coef;
    typedef logic signed [PROD_BITS-1:0] t_prod;

    // One item between de Casteljau levels.
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [CNT_BITS-1:0]   cnt;
        logic                  bad;
        t_coef [LANES-1:0]     pos;
        t_coef [LANES-1:0]     vel;
        t_coef [LANES-1:0]     acc;
    } t_work;

    // One item between the multiply and the accumulate half of a level.
    typedef struct packed {
        t_work             work;
        logic              en_pos;
        logic              en_vel;
        logic              en_acc;
        t_prod [LANES-2:0] pp;
        t_prod [LANES-2:0] pv;
        t_prod [LANES-2:0] pa;
    } t_step;

endpackage

[hw/rtl/bce_intf.sv]
// ----------------------------------------------------------------------------
// Bezier curve evaluator channel interfaces
// Input item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bce_in_if import bce_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [PHASE_BITS-1:0]        phase;
    logic [CNT_BITS-1:0]          mid_count;
    logic signed [COORD_BITS-1:0] start_pt;
    logic signed [COORD_BITS-1:0] end_pt;
    logic signed [COORD_BITS-1:0] mid_0;
    logic signed [COORD_BITS-1:0] mid_1;
    logic signed [COORD_BITS-1:0] mid_2;
    logic signed [COORD_BITS-1:0] mid_3;

    modport source (output valid, phase, mid_count, start_pt, end_pt,
                    mid_0, mid_1, mid_2, mid_3, input ready);
    modport sink   (input valid, phase, mid_count, start_pt, end_pt,
                    mid_0, mid_1, mid_2, mid_3, output ready);
endinterface

interface bce_out_if import bce_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] position;
    logic signed [OUT_BITS-1:0] velocity;
    logic signed [OUT_BITS-1:0] acceleration;
    logic                       bad_degree;

    modport source (output valid, position, velocity, acceleration, bad_degree,
                    input ready);
    modport sink   (input valid, position, velocity, acceleration, bad_degree,
                    output ready);
endinterface

[hw/rtl/bce_prep.sv]
// ----------------------------------------------------------------------------
// Bezier curve evaluator front end
// Registers the item, orders the control points and forms the differences.
// ----------------------------------------------------------------------------
module bce_prep import bce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bce_in_if.sink     i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_work      o_work
);

    logic  r_v0, r_v1;
    t_work r_w0, r_w1, n_w0, n_w1;
    logic  rdy0, rdy1;
    logic signed [COORD_BITS-1:0] mids [4];

    assign rdy1         = !r_v1 || i_ready;
    assign rdy0         = !r_v0 || rdy1;
    assign i_item.ready = rdy0;
    assign o_valid      = r_v1;
    assign o_work       = r_w1;

    assign mids[0] = i_item.mid_0;
    assign mids[1] = i_item.mid_1;
    assign mids[2] = i_item.mid_2;
    assign mids[3] = i_item.mid_3;

    // Points in curve order: start, the used inner points, then end.
    always_comb begin
        n_w0       = '0;
        n_w0.phase = (i_item.phase > PHASE_ONE) ? PHASE_ONE : i_item.phase;
        n_w0.cnt   = i_item.mid_count;
        n_w0.bad   = (i_item.mid_count < MIN_COUNT) || (i_item.mid_count > MAX_COUNT);
        n_w0.pos[0] = t_coef'(i_item.start_pt);
        for (int l = 1; l < LANES; l++) begin
            if (l <= 4 && l <= int'(i_item.mid_count)) begin
                n_w0.pos[l] = t_coef'(mids[l-1]);
            end else begin
                n_w0.pos[l] = t_coef'(i_item.end_pt);
            end
        end
    end

    always_comb begin
        n_w1 = r_w0;
        for (int i = 0; i < LANES; i++) begin
            n_w1.vel[i] = '0;
            n_w1.acc[i] = '0;
        end
        for (int i = 0; i < LANES - 1; i++) begin
            n_w1.vel[i] = r_w0.pos[i+1] - r_w0.pos[i];
        end
        for (int i = 0; i < LANES - 2; i++) begin
            n_w1.acc[i] = r_w0.pos[i+2] - (r_w0.pos[i+1] <<< 1) + r_w0.pos[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_item.valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_item.valid) begin
            r_w0 <= n_w0;
        end
        if (rdy1 && r_v0) begin
            r_w1 <= n_w1;
        end
    end

endmodule

[hw/rtl/bce_level.sv]
// ----------------------------------------------------------------------------
// Bezier curve evaluator de Casteljau level
// One interpolation level for all three curves: multiply, then round and add.
// ----------------------------------------------------------------------------
module bce_level import bce_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [LVL_BITS-1:0] i_level,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_work               i_work,
    output logic                o_valid,
    input  logic                i_ready,
    output t_work               o_work
);

    logic  r_va, r_vb;
    t_step r_a, n_a;
    t_work r_b, n_b;
    logic  rdy_a, rdy_b;
    logic [LVL_BITS:0] lvl, cnt_x;

    function automatic t_prod step_mul(t_coef a, t_coef b, logic [PHASE_BITS-1:0] t);
        logic signed [DIFF_BITS-1:0]  d;
        logic signed [PHASE_BITS:0]   ts;
        d  = DIFF_BITS'(b) - DIFF_BITS'(a);
        ts = $signed({1'b0, t});
        return PROD_BITS'(d) * PROD_BITS'(ts);
    endfunction

    // Rounds to nearest, ties away from zero, then adds to the left point.
    function automatic t_coef step_add(t_coef a, t_prod p);
        t_prod r;
        t_prod s;
        r = p[PROD_BITS-1] ? t_prod'((1 << (PHASE_FRAC_BITS - 1)) - 1)
                           : t_prod'(1 << (PHASE_FRAC_BITS - 1));
        s = (p + r) >>> PHASE_FRAC_BITS;
        return a + s[WORK_BITS-1:0];
    endfunction

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;
    assign o_work  = r_b;

    assign lvl   = {1'b0, i_level};
    assign cnt_x = {1'b0, i_work.cnt};

    always_comb begin
        n_a        = '0;
        n_a.work   = i_work;
        // Point counts are cnt+2, cnt+1 and cnt; a curve of k points has k-1 levels.
        n_a.en_pos = lvl <= cnt_x + 1'b1;
        n_a.en_vel = lvl <= cnt_x;
        n_a.en_acc = lvl + 1'b1 <= cnt_x;
        for (int i = 0; i < LANES - 1; i++) begin
            n_a.pp[i] = step_mul(i_work.pos[i], i_work.pos[i+1], i_work.phase);
            n_a.pv[i] = step_mul(i_work.vel[i], i_work.vel[i+1], i_work.phase);
            n_a.pa[i] = step_mul(i_work.acc[i], i_work.acc[i+1], i_work.phase);
        end
    end

    always_comb begin
        n_b = r_a.work;
        for (int i = 0; i < LANES - 1; i++) begin
            if (r_a.en_pos) begin
                n_b.pos[i] = step_add(r_a.work.pos[i], r_a.pp[i]);
            end
            if (r_a.en_vel) begin
                n_b.vel[i] = step_add(r_a.work.vel[i], r_a.pv[i]);
            end
            if (r_a.en_acc) begin
                n_b.acc[i] = step_add(r_a.work.acc[i], r_a.pa[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a <= n_a;
        end
        if (rdy_b && r_va) begin
            r_b <= n_b;
        end
    end

endmodule

[hw/rtl/bce_out_stage.sv]
// ----------------------------------------------------------------------------
// Bezier curve evaluator output stage
// Applies the degree factors to the derivatives and holds the result item.
// ----------------------------------------------------------------------------
module bce_out_stage import bce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_work      i_work,
    bce_out_if.source  o_item
);

    logic r_v;
    logic signed [OUT_BITS-1:0] r_pos, r_vel, r_acc;
    logic signed [OUT_BITS-1:0] n_pos, n_vel, n_acc;
    logic r_bad;
    logic rdy;
    logic [FACT_BITS-1:0] deg, deg2;

    assign rdy     = !r_v || o_item.ready;
    assign o_ready = rdy;

    assign o_item.valid        = r_v;
    assign o_item.position     = r_pos;
    assign o_item.velocity     = r_vel;
    assign o_item.acceleration = r_acc;
    assign o_item.bad_degree   = r_bad;

    // Degree is count plus one; the factors are n and n(n-1). With points held
    // to 34 bits the scaled values stay well inside 48 bits, so no clamp is needed.
    assign deg  = FACT_BITS'(i_work.cnt) + 1'b1;
    assign deg2 = FACT_BITS'(deg * FACT_BITS'(i_work.cnt));

    always_comb begin
        if (i_work.bad) begin
            n_pos = '0;
            n_vel = '0;
            n_acc = '0;
        end else begin
            n_pos = OUT_BITS'(i_work.pos[0]);
            n_vel = OUT_BITS'(i_work.vel[0]) * OUT_BITS'($signed({1'b0, deg}));
            n_acc = OUT_BITS'(i_work.acc[0]) * OUT_BITS'($signed({1'b0, deg2}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_pos <= n_pos;
            r_vel <= n_vel;
            r_acc <= n_acc;
            r_bad <= i_work.bad;
        end
    end

endmodule

[hw/rtl/bezier_curve_evaluator.sv]
// ----------------------------------------------------------------------------
// Bezier curve evaluator
// Position, first and second derivative of a degree 2 to 5 Bezier curve.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  i_item    in         phase, mid_count, start_pt, end_pt, mid_0 .. mid_3
//  o_item    out        position, velocity, acceleration, bad_degree
//
// An item passes thirteen registers: two front-end stages, two per de Casteljau
// level for five levels, and the output register. One item is accepted every
// cycle while no stall holds the pipeline; each multiplier per lane in each level
// is registered before its rounding add, so every stage holds one item.
// Reset empties every stage; each stage keeps its item while the one after it
// is full and stalled, so empty stages still fill while the output waits.
//
// The three curves (points, first differences, second differences) are
// evaluated side by side. A level only updates a curve while that curve still
// has levels to go for the item's degree, so shorter curves pass through.
// ----------------------------------------------------------------------------
`include "bezier_curve_evaluator_assert.svh"

module bezier_curve_evaluator import bce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bce_in_if.sink     i_item,
    bce_out_if.source  o_item
);

    logic  v   [LEVELS+1];
    logic  rdy [LEVELS+1];
    t_work w   [LEVELS+1];

    // Front end: clamp the phase, order the points, form the differences.
    bce_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_work  (w[0])
    );

    // Five interpolation levels, enough for six control points.
    for (genvar j = 0; j < LEVELS; j++) begin : g_level
        bce_level u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_level (LVL_BITS'(j + 1)),
            .i_valid (v[j]),
            .o_ready (rdy[j]),
            .i_work  (w[j]),
            .o_valid (v[j+1]),
            .i_ready (rdy[j+1]),
            .o_work  (w[j+1])
        );
    end

    // Degree factors and the result register.
    bce_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[LEVELS]),
        .o_ready (rdy[LEVELS]),
        .i_work  (w[LEVELS]),
        .o_item  (o_item)
    );

    // An unsupported count gives an all-zero result.
    `BCE_ASSERT_IMP(a_bad_zero, i_clk, !i_rst_n, o_item.valid && o_item.bad_degree, o_item.position == '0 && o_item.velocity == '0 && o_item.acceleration == '0)
    // Reset leaves no result item behind.
    `BCE_ASSERT_NXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_item.valid)
    // The curve stays inside the hull of its points, so it fits the coordinate width.
    `BCE_ASSERT_IMP(a_pos_hull, i_clk, !i_rst_n, o_item.valid && !o_item.bad_degree, (&o_item.position[OUT_BITS-1:COORD_BITS-1]) || !(|o_item.position[OUT_BITS-1:COORD_BITS-1]))

endmodule
